/* src/dtbw_pkg.sv */
// Shared types, constants and arithmetic steps of the distance tier blend weight block.
`default_nettype none

package dtbw_pkg;

  localparam int unsigned DistW     = 26;
  localparam int unsigned EndW      = 25;
  localparam int unsigned FracW     = 15;
  localparam int unsigned PosW      = 25;
  localparam int unsigned DiffW     = 26;
  localparam int unsigned SqW       = 52;
  localparam int unsigned RootW     = 26;
  localparam int unsigned RootSteps = 26;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned WgtW      = 17;
  localparam int unsigned QuotW     = 16;
  localparam int unsigned DivW      = 26;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [WgtW-1:0] OneQ16 = 17'd65536;

  localparam logic [EndW-1:0]  NearMin  = 25'd256;
  localparam logic [EndW-1:0]  NearMax  = 25'd25599488;
  localparam logic [EndW-1:0]  MidMin   = 25'd512;
  localparam logic [EndW-1:0]  MidMax   = 25'd25599744;
  localparam logic [EndW-1:0]  FarMin   = 25'd768;
  localparam logic [EndW-1:0]  FarMax   = 25'd25600000;
  localparam logic [FracW-1:0] FracMin  = 15'd655;
  localparam logic [FracW-1:0] FracMax  = 15'd32113;
  localparam logic [EndW-1:0]  TierGap  = 25'd256;

  localparam logic [EndW-1:0]  NearRst  = 25'd30720;
  localparam logic [EndW-1:0]  MidRst   = 25'd204800;
  localparam logic [EndW-1:0]  FarRst   = 25'd1024000;
  localparam logic [FracW-1:0] FracRst  = 15'd7864;

  typedef enum logic [1:0] {
    REG_NEAR_END   = 2'd0,
    REG_MIDDLE_END = 2'd1,
    REG_FAR_END    = 2'd2,
    REG_TRANS_FRAC = 2'd3
  } dtbw_reg_e;

  // Tier geometry derived from the configuration registers.
  typedef struct packed {
    logic [DivW-1:0] lo_n;
    logic [DivW-1:0] hi_n;
    logic [DivW-1:0] den_n;
    logic [DivW-1:0] lo_f;
    logic [DivW-1:0] hi_f;
    logic [DivW-1:0] den_f;
    logic [EndW-1:0] far_end;
  } dtbw_tier_cfg_t;

  typedef struct packed {
    logic [DivW-1:0]  r;
    logic [QuotW-1:0] q;
  } dtbw_div_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [SqW-1:0]   rad;
  } dtbw_root_t;

  // One bit of a restoring division; the remainder stays below the divisor.
  function automatic dtbw_div_t div_step(input logic [DivW-1:0] r,
                                         input logic [QuotW-1:0] q,
                                         input logic [DivW-1:0] b);
    logic [DivW:0] r2;
    dtbw_div_t     res;
    r2 = {r, 1'b0};
    if (r2 >= {1'b0, b}) begin
      res.r = DivW'(r2 - {1'b0, b});
      res.q = {q[QuotW-2:0], 1'b1};
    end else begin
      res.r = r2[DivW-1:0];
      res.q = {q[QuotW-2:0], 1'b0};
    end
    return res;
  endfunction

  // One result bit of a digit-by-digit integer square root.
  function automatic dtbw_root_t root_step(input dtbw_root_t s);
    logic [RemW-1:0] cur;
    logic [RemW-1:0] trial;
    dtbw_root_t      res;
    cur   = {s.rem[RemW-3:0], s.rad[SqW-1:SqW-2]};
    trial = {1'b0, s.root, 2'b01};
    res.rad = {s.rad[SqW-3:0], 2'b00};
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {s.root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/dtbw_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface dtbw_in_if;
  import dtbw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [DistW-1:0]        given_distance;
  logic signed [PosW-1:0]  camera_x;
  logic signed [PosW-1:0]  camera_y;
  logic signed [PosW-1:0]  camera_z;
  logic signed [PosW-1:0]  surface_x;
  logic signed [PosW-1:0]  surface_y;
  logic signed [PosW-1:0]  surface_z;

  modport source (output valid, action, given_distance, camera_x, camera_y, camera_z,
                  surface_x, surface_y, surface_z, input ready);
  modport sink (input valid, action, given_distance, camera_x, camera_y, camera_z,
                surface_x, surface_y, surface_z, output ready);
endinterface

interface dtbw_out_if;
  import dtbw_pkg::*;
  logic            valid;
  logic            ready;
  logic [WgtW-1:0] near_weight;
  logic [WgtW-1:0] middle_weight;
  logic [WgtW-1:0] far_weight;
  logic [WgtW-1:0] normalized_distance;

  modport source (output valid, near_weight, middle_weight, far_weight, normalized_distance,
                  input ready);
  modport sink (input valid, near_weight, middle_weight, far_weight, normalized_distance,
                output ready);
endinterface

`default_nettype wire

/* src/dtbw_divider.sv */
// Pipelined restoring divider producing one quotient bit per enabled stage.
`default_nettype none

module dtbw_divider import dtbw_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DivW-1:0]  a_i,
  input  logic [DivW-1:0]  b_i,
  output logic [QuotW-1:0] q_o
);

  dtbw_div_t       st_q  [QuotW];
  logic [DivW-1:0] den_q [QuotW];

  // The dividend must be below the divisor; the quotient is a 16 bit fraction.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= div_step(a_i, '0, b_i);
      den_q[0] <= b_i;
      for (int k = 1; k < QuotW; k++) begin
        st_q[k]  <= div_step(st_q[k-1].r, st_q[k-1].q, den_q[k-1]);
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign q_o = st_q[QuotW-1].q;

endmodule

`default_nettype wire

/* src/dtbw_front.sv */
// Front end: accepts items and forms the distance, by square root when positions are given.
`default_nettype none

module dtbw_front import dtbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  dtbw_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [DistW-1:0] dist_o
);

  function automatic logic [DiffW-1:0] abs_diff(input logic [PosW-1:0] s,
                                                input logic [PosW-1:0] c);
    logic [DiffW-1:0] diff;
    diff = {s[PosW-1], s} - {c[PosW-1], c};
    return diff[DiffW-1] ? DiffW'(-diff) : diff;
  endfunction

  logic             en;

  logic             v0_q, act0_q;
  logic [DistW-1:0] gd0_q;
  logic [PosW-1:0]  cx0_q, cy0_q, cz0_q, sx0_q, sy0_q, sz0_q;

  logic             v1_q, act1_q;
  logic [DistW-1:0] gd1_q;
  logic [DiffW-1:0] mx1_q, my1_q, mz1_q;

  logic             v2_q, act2_q;
  logic [DistW-1:0] gd2_q;
  logic [SqW-1:0]   qx2_q, qy2_q, qz2_q;

  logic             v3_q, act3_q;
  logic [DistW-1:0] gd3_q;
  logic [SqW-1:0]   rad3_q;

  logic             sv_q   [RootSteps];
  logic             sact_q [RootSteps];
  logic [DistW-1:0] sgd_q  [RootSteps];
  dtbw_root_t       sst_q  [RootSteps];

  // The whole front advances together; it holds only when its last stage cannot drain.
  assign en       = !(sv_q[RootSteps-1] && full_i);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < RootSteps; k++) begin
        sv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= in_i.valid;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      sv_q[0] <= v3_q;
      for (int k = 1; k < RootSteps; k++) begin
        sv_q[k] <= sv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act0_q <= in_i.action;
      gd0_q  <= in_i.given_distance;
      cx0_q  <= in_i.camera_x;
      cy0_q  <= in_i.camera_y;
      cz0_q  <= in_i.camera_z;
      sx0_q  <= in_i.surface_x;
      sy0_q  <= in_i.surface_y;
      sz0_q  <= in_i.surface_z;

      act1_q <= act0_q;
      gd1_q  <= gd0_q;
      mx1_q  <= abs_diff(sx0_q, cx0_q);
      my1_q  <= abs_diff(sy0_q, cy0_q);
      mz1_q  <= abs_diff(sz0_q, cz0_q);

      act2_q <= act1_q;
      gd2_q  <= gd1_q;
      qx2_q  <= SqW'(mx1_q) * SqW'(mx1_q);
      qy2_q  <= SqW'(my1_q) * SqW'(my1_q);
      qz2_q  <= SqW'(mz1_q) * SqW'(mz1_q);

      act3_q <= act2_q;
      gd3_q  <= gd2_q;
      rad3_q <= qx2_q + qy2_q + qz2_q;

      sact_q[0] <= act3_q;
      sgd_q[0]  <= gd3_q;
      sst_q[0]  <= root_step('{rem: '0, root: '0, rad: rad3_q});
      for (int k = 1; k < RootSteps; k++) begin
        sact_q[k] <= sact_q[k-1];
        sgd_q[k]  <= sgd_q[k-1];
        sst_q[k]  <= root_step(sst_q[k-1]);
      end
    end
  end

  assign push_o = sv_q[RootSteps-1] && !full_i;
  assign dist_o = sact_q[RootSteps-1] ? sst_q[RootSteps-1].root : sgd_q[RootSteps-1];

endmodule

`default_nettype wire

/* src/dtbw_fifo.sv */
// Short distance queue between the front end and the back end.
`default_nettype none

module dtbw_fifo import dtbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DistW-1:0] data_i,
  input  logic             pop_i,
  output logic [DistW-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [DistW-1:0]    mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? FifoPtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? FifoPtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* src/dtbw_back.sv */
// Back end: smoothstep tier edges, weight normalization and distance ratio.
`default_nettype none

module dtbw_back import dtbw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dtbw_tier_cfg_t   cfg_i,
  input  logic             empty_i,
  input  logic [DistW-1:0] data_i,
  output logic             pop_o,
  dtbw_out_if.source       out_o
);

  typedef struct packed {
    logic below_n;
    logic above_n;
    logic below_f;
    logic above_f;
    logic sat;
  } edge_flags_t;

  typedef struct packed {
    logic            byp;
    logic [WgtW-1:0] wn;
    logic [WgtW-1:0] wm;
    logic [WgtW-1:0] wf;
    logic [WgtW-1:0] nd;
  } norm_side_t;

  localparam logic [17:0] Smooth3   = 18'd196608;
  localparam logic [50:0] RoundHalf = 51'd2147483648;
  localparam logic [17:0] SumOne    = 18'd65536;

  logic en;

  logic            v0_q;
  edge_flags_t     fl0_q;
  logic [DivW-1:0] an0_q, af0_q, ad0_q;

  logic            v1_q [QuotW];
  edge_flags_t     fl1_q [QuotW];
  logic [QuotW-1:0] qn, qf, qd;

  logic            vs1_q, vs2_q, vs3_q, vs4_q;
  logic [WgtW-1:0] tn1_q, tf1_q, nd1_q, nd2_q, nd3_q;
  logic [32:0]     ttn2_q, ttf2_q;
  logic [17:0]     kn2_q, kf2_q;
  logic [WgtW-1:0] emn3_q, emf3_q;
  norm_side_t      s4_q;
  logic [17:0]     sum4_q;

  logic            v2_q [QuotW];
  norm_side_t      sd2_q [QuotW];
  logic [QuotW-1:0] qwn, qwm, qwf;

  logic            ov_q;
  logic [WgtW-1:0] on_q, om_q, of_q, od_q;

  logic [DistW-1:0] d;
  edge_flags_t      fl;
  logic [50:0]      pn, pf;
  logic [WgtW-1:0]  wn, wm, wf;
  logic [17:0]      sum;

  // The back end holds whenever the output register is full and not taken.
  assign en    = !ov_q || out_o.ready;
  assign pop_o = en && !empty_i;
  assign d     = data_i;

  always_comb begin
    fl.below_n = d <= cfg_i.lo_n;
    fl.above_n = d >= cfg_i.hi_n;
    fl.below_f = d <= cfg_i.lo_f;
    fl.above_f = d >= cfg_i.hi_f;
    fl.sat     = d >= {1'b0, cfg_i.far_end};
    pn = 51'(ttn2_q) * 51'(kn2_q);
    pf = 51'(ttf2_q) * 51'(kf2_q);
    wn  = OneQ16 - emn3_q;
    wm  = (emn3_q > emf3_q) ? WgtW'(emn3_q - emf3_q) : '0;
    wf  = emf3_q;
    sum = 18'(wn) + 18'(wm) + 18'(wf);
  end

  dtbw_divider u_div_n (.clk_i, .en_i(en), .a_i(an0_q), .b_i(cfg_i.den_n), .q_o(qn));
  dtbw_divider u_div_f (.clk_i, .en_i(en), .a_i(af0_q), .b_i(cfg_i.den_f), .q_o(qf));
  dtbw_divider u_div_d (.clk_i, .en_i(en), .a_i(ad0_q), .b_i(DivW'(cfg_i.far_end)),
                        .q_o(qd));

  dtbw_divider u_div_wn (.clk_i, .en_i(en), .a_i(s4_q.byp ? '0 : DivW'(s4_q.wn)),
                         .b_i(DivW'(sum4_q)), .q_o(qwn));
  dtbw_divider u_div_wm (.clk_i, .en_i(en), .a_i(s4_q.byp ? '0 : DivW'(s4_q.wm)),
                         .b_i(DivW'(sum4_q)), .q_o(qwm));
  dtbw_divider u_div_wf (.clk_i, .en_i(en), .a_i(s4_q.byp ? '0 : DivW'(s4_q.wf)),
                         .b_i(DivW'(sum4_q)), .q_o(qwf));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      vs1_q <= 1'b0;
      vs2_q <= 1'b0;
      vs3_q <= 1'b0;
      vs4_q <= 1'b0;
      ov_q  <= 1'b0;
      for (int k = 0; k < QuotW; k++) begin
        v1_q[k] <= 1'b0;
        v2_q[k] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= pop_o;
      v1_q[0] <= v0_q;
      for (int k = 1; k < QuotW; k++) begin
        v1_q[k] <= v1_q[k-1];
      end
      vs1_q   <= v1_q[QuotW-1];
      vs2_q   <= vs1_q;
      vs3_q   <= vs2_q;
      vs4_q   <= vs3_q;
      v2_q[0] <= vs4_q;
      for (int k = 1; k < QuotW; k++) begin
        v2_q[k] <= v2_q[k-1];
      end
      ov_q <= v2_q[QuotW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl0_q <= fl;
      an0_q <= (fl.below_n || fl.above_n) ? '0 : DivW'(d - cfg_i.lo_n);
      af0_q <= (fl.below_f || fl.above_f) ? '0 : DivW'(d - cfg_i.lo_f);
      ad0_q <= fl.sat ? '0 : d;

      fl1_q[0] <= fl0_q;
      for (int k = 1; k < QuotW; k++) begin
        fl1_q[k] <= fl1_q[k-1];
      end

      tn1_q <= fl1_q[QuotW-1].below_n ? '0 :
               fl1_q[QuotW-1].above_n ? OneQ16 : WgtW'(qn);
      tf1_q <= fl1_q[QuotW-1].below_f ? '0 :
               fl1_q[QuotW-1].above_f ? OneQ16 : WgtW'(qf);
      nd1_q <= fl1_q[QuotW-1].sat ? OneQ16 : WgtW'(qd);

      ttn2_q <= 33'(34'(tn1_q) * 34'(tn1_q));
      ttf2_q <= 33'(34'(tf1_q) * 34'(tf1_q));
      kn2_q  <= Smooth3 - {tn1_q, 1'b0};
      kf2_q  <= Smooth3 - {tf1_q, 1'b0};
      nd2_q  <= nd1_q;

      emn3_q <= WgtW'((pn + RoundHalf) >> 32);
      emf3_q <= WgtW'((pf + RoundHalf) >> 32);
      nd3_q  <= nd2_q;

      s4_q.wn  <= wn;
      s4_q.wm  <= wm;
      s4_q.wf  <= wf;
      s4_q.byp <= (sum == SumOne);
      s4_q.nd  <= nd3_q;
      sum4_q   <= sum;

      sd2_q[0] <= s4_q;
      for (int k = 1; k < QuotW; k++) begin
        sd2_q[k] <= sd2_q[k-1];
      end

      on_q <= sd2_q[QuotW-1].byp ? sd2_q[QuotW-1].wn : WgtW'(qwn);
      om_q <= sd2_q[QuotW-1].byp ? sd2_q[QuotW-1].wm : WgtW'(qwm);
      of_q <= sd2_q[QuotW-1].byp ? sd2_q[QuotW-1].wf : WgtW'(qwf);
      od_q <= sd2_q[QuotW-1].nd;
    end
  end

  assign out_o.valid               = ov_q;
  assign out_o.near_weight         = on_q;
  assign out_o.middle_weight       = om_q;
  assign out_o.far_weight          = of_q;
  assign out_o.normalized_distance = od_q;

endmodule

`default_nettype wire

/* src/distance_tier_blend_weights.sv */
// Top level of the distance tier blend weight block with its register port.
//
// Input items arrive as beats on in_i (valid/ready); each carries either a distance or a
// camera and a surface position, in which case the Euclidean distance is taken by an
// integer square root. Every input beat yields exactly one result beat on out_o with the
// near, middle and far blend weights and the distance over the far tier end, all Q1.16.
// The four registers (near end, middle end, far end, transition fraction) sit on an
// APB-style port at byte addresses 0, 4, 8 and 12; pready is always high and reads return
// the written values. Writes belong in idle periods; the derived tier geometry settles
// through the registers ne1_q to ne5_q and cfg_q, well inside the front end's latency.
// Throughput is one beat per cycle when nothing stalls. From acceptance to the result beat
// an item passes 4 front stages and 26 square root stages, the queue, the back end's entry
// stage, 16 division stages, 4 smoothstep and weight stages, 16 normalization division
// stages and the output register. A four-entry queue between front and back lets each
// side hold on its own. When the receiver stalls, the back end freezes with its result
// in the output register; the front keeps accepting until the queue and its own stages
// fill.
// Reset empties all stages and the queue and restores the register reset values.
`default_nettype none

module distance_tier_blend_weights import dtbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtbw_in_if.sink     in_i,
  dtbw_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  function automatic logic [EndW-1:0] clamp_end(input logic [EndW-1:0] v,
                                                 input logic [EndW-1:0] lo,
                                                 input logic [EndW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  logic [EndW-1:0]  near_q, mid_q, far_q;
  logic [FracW-1:0] frac_q;
  logic             wr_en;

  // Derived configuration chain.
  logic [EndW-1:0]  ne1_q, me1_q, fe1_q, ne2_q, me2_q, fe2_q, ne3_q, me3_q, fe3_q;
  logic [EndW-1:0]  ne4_q, me4_q, fe4_q, mn4_q, mf4_q, ne5_q, me5_q, fe5_q;
  logic [EndW-1:0]  hwn5_q, hwf5_q;
  logic [FracW-1:0] fr1_q, fr2_q, fr3_q, fr4_q;
  logic [EndW-1:0]  me_ord, fe_ord, span_m, span_f;
  logic [EndW+FracW-1:0] prod_n, prod_f;
  logic [EndW-1:0]  hw_n, hw_f;
  dtbw_tier_cfg_t   cfg_q;

  logic             fifo_full, fifo_empty, push, pop;
  logic [DistW-1:0] push_dist, pop_dist;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearRst;
      mid_q  <= MidRst;
      far_q  <= FarRst;
      frac_q <= FracRst;
    end else if (wr_en) begin
      case (dtbw_reg_e'(paddr[3:2]))
        REG_NEAR_END:   near_q <= pwdata[EndW-1:0];
        REG_MIDDLE_END: mid_q  <= pwdata[EndW-1:0];
        REG_FAR_END:    far_q  <= pwdata[EndW-1:0];
        REG_TRANS_FRAC: frac_q <= pwdata[FracW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dtbw_reg_e'(paddr[3:2]))
      REG_NEAR_END:   prdata = 32'(near_q);
      REG_MIDDLE_END: prdata = 32'(mid_q);
      REG_FAR_END:    prdata = 32'(far_q);
      REG_TRANS_FRAC: prdata = 32'(frac_q);
      default:        prdata = '0;
    endcase
  end

  // The middle end is pushed above the near end, then the far end above the middle end.
  always_comb begin
    me_ord = (me1_q <= ne1_q) ?
             ((ne1_q + TierGap > MidMax) ? MidMax : EndW'(ne1_q + TierGap)) : me1_q;
    fe_ord = (fe2_q <= me2_q) ?
             ((me2_q + TierGap > FarMax) ? FarMax : EndW'(me2_q + TierGap)) : fe2_q;
    span_m = me3_q - ne3_q;
    span_f = fe3_q - me3_q;
    prod_n = (EndW+FracW)'(mn4_q) * (EndW+FracW)'(fr4_q);
    prod_f = (EndW+FracW)'(mf4_q) * (EndW+FracW)'(fr4_q);
    hw_n   = EndW'(prod_n >> 16);
    hw_f   = EndW'(prod_f >> 16);
    if (hw_n == '0) begin
      hw_n = EndW'(1);
    end
    if (hw_f == '0) begin
      hw_f = EndW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ne1_q <= clamp_end(near_q, NearMin, NearMax);
    me1_q <= clamp_end(mid_q, MidMin, MidMax);
    fe1_q <= clamp_end(far_q, FarMin, FarMax);
    fr1_q <= (frac_q < FracMin) ? FracMin : ((frac_q > FracMax) ? FracMax : frac_q);

    ne2_q <= ne1_q;
    me2_q <= me_ord;
    fe2_q <= fe1_q;
    fr2_q <= fr1_q;

    ne3_q <= ne2_q;
    me3_q <= me2_q;
    fe3_q <= fe_ord;
    fr3_q <= fr2_q;

    ne4_q <= ne3_q;
    me4_q <= me3_q;
    fe4_q <= fe3_q;
    fr4_q <= fr3_q;
    mn4_q <= (ne3_q < span_m) ? ne3_q : span_m;
    mf4_q <= (span_m < span_f) ? span_m : span_f;

    ne5_q  <= ne4_q;
    me5_q  <= me4_q;
    fe5_q  <= fe4_q;
    hwn5_q <= hw_n;
    hwf5_q <= hw_f;

    // The transition window is clipped at zero, so its width is then edge plus half width.
    cfg_q.lo_n    <= (ne5_q > hwn5_q) ? DivW'(ne5_q - hwn5_q) : '0;
    cfg_q.hi_n    <= DivW'(ne5_q) + DivW'(hwn5_q);
    cfg_q.den_n   <= (ne5_q > hwn5_q) ? {hwn5_q, 1'b0} : DivW'(ne5_q) + DivW'(hwn5_q);
    cfg_q.lo_f    <= (me5_q > hwf5_q) ? DivW'(me5_q - hwf5_q) : '0;
    cfg_q.hi_f    <= DivW'(me5_q) + DivW'(hwf5_q);
    cfg_q.den_f   <= (me5_q > hwf5_q) ? {hwf5_q, 1'b0} : DivW'(me5_q) + DivW'(hwf5_q);
    cfg_q.far_end <= fe5_q;
  end

  dtbw_front u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .full_i (fifo_full),
    .push_o (push),
    .dist_o (push_dist)
  );

  dtbw_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_dist),
    .pop_i   (pop),
    .data_o  (pop_dist),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  dtbw_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg_q),
    .empty_i (fifo_empty),
    .data_i  (pop_dist),
    .pop_o   (pop),
    .out_o
  );

endmodule

`default_nettype wire

/* src/dtbw_checker.sv */
// Port-level checks on the result channel of the distance tier blend weight block.
`default_nettype none

module dtbw_checker import dtbw_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [WgtW-1:0] near_i,
  input logic [WgtW-1:0] middle_i,
  input logic [WgtW-1:0] far_i,
  input logic [WgtW-1:0] nd_i
);

  logic [WgtW+1:0] wsum;

  assign wsum = (WgtW+2)'(near_i) + (WgtW+2)'(middle_i) + (WgtW+2)'(far_i);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(near_i) && $stable(middle_i) && $stable(far_i)
    && $stable(nd_i))
    else $error("result payload changed while stalled");

  // Normalization floors each weight, so the sum falls short of one by at most two.
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wsum <= (WgtW+2)'(65536)) && (wsum >= (WgtW+2)'(65534)))
    else $error("blend weights do not sum to one");

  a_full_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (near_i == OneQ16) |-> (middle_i == '0) && (far_i == '0))
    else $error("full near weight with other weights set");

endmodule

bind distance_tier_blend_weights dtbw_checker u_dtbw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .near_i      (out_o.near_weight),
  .middle_i    (out_o.middle_weight),
  .far_i       (out_o.far_weight),
  .nd_i        (out_o.normalized_distance)
);

`default_nettype wire
